// ===== rtl/arrd_pkg.sv =====
// Shared types, constants and helper functions for the altitude rolling digit readout.
package arrd_pkg;

    localparam int RAW_W      = 16;
    localparam int FRAC_W     = 3;
    localparam int COUNT_W    = RAW_W - FRAC_W;
    localparam int GLYPH_W    = 4;
    localparam int OFFSET_W   = 12;
    localparam int COL_W      = 2;
    localparam int NUM_COLS   = 4;

    localparam int BASE_POS   = 886;
    localparam int FRAC_MASK  = 'h07;
    localparam int LOW_SCALE  = 61;
    localparam int HIGH_SCALE = 6;
    localparam int CARRY_G    = 24;
    localparam int K_LOW_MAX  = 8;
    localparam int K_HIGH_MAX = 80;
    localparam int LOW_LIMIT  = 100;
    localparam int THOUSAND   = 1000;

    localparam logic [GLYPH_W-1:0] BLANK_CODE = 4'd10;
    localparam logic [COL_W-1:0]   LAST_COL   = 2'd3;

    // reciprocal multipliers, exact floor for any 13-bit count
    localparam int RECIP_10   = 6554;   // >> 16
    localparam int RECIP_100  = 5243;   // >> 19
    localparam int RECIP_1000 = 8389;   // >> 23

    typedef struct packed {
        logic [COUNT_W-1:0] n;
        logic [FRAC_W-1:0]  frac;
        logic [9:0]         q1;   // n / 10
        logic [6:0]         q2;   // n / 100
        logic [3:0]         q3;   // n / 1000
    } arrd_quot_t;

    typedef struct packed {
        logic [GLYPH_W-1:0]         glyph_next;
        logic [GLYPH_W-1:0]         glyph_current;
        logic [GLYPH_W-1:0]         glyph_prev;
        logic signed [OFFSET_W-1:0] drum_offset;
    } arrd_col_t;

    typedef arrd_col_t [NUM_COLS-1:0] arrd_frame_t;

    // prod is value * scale; the drum position is 2 * (prod / 4 - BASE_POS)
    function automatic logic signed [OFFSET_W-1:0] roll_offset(input logic [8:0] prod);
        logic [OFFSET_W-1:0] twice;
        twice = OFFSET_W'({prod[8:2], 1'b0});
        return signed'(twice - OFFSET_W'(2 * BASE_POS));
    endfunction

    function automatic logic [GLYPH_W-1:0] blank_glyph(input logic [GLYPH_W-1:0] d,
                                                       input logic blank_zero,
                                                       input logic all_blank);
        logic [GLYPH_W-1:0] g;
        g = d;
        if (all_blank || (blank_zero && d == 4'd0))
            g = BLANK_CODE;
        return g;
    endfunction

    function automatic arrd_col_t make_col(input logic [GLYPH_W-1:0] d,
                                           input logic blank_zero,
                                           input logic all_blank,
                                           input logic signed [OFFSET_W-1:0] offset);
        arrd_col_t          c;
        logic [GLYPH_W-1:0] nxt;
        logic [GLYPH_W-1:0] prv;
        nxt = (d == 4'd9) ? 4'd0 : d + 4'd1;
        prv = (d == 4'd0) ? 4'd9 : d - 4'd1;
        c.glyph_next    = blank_glyph(nxt, blank_zero, all_blank);
        c.glyph_current = blank_glyph(d, blank_zero, all_blank);
        c.glyph_prev    = blank_glyph(prv, blank_zero, all_blank);
        c.drum_offset   = offset;
        return c;
    endfunction

endpackage

// ===== rtl/arrd_in_if.sv =====
// Input channel carrying one raw altitude word per transaction.
interface arrd_in_if;
    import arrd_pkg::*;

    logic               valid;
    logic               ready;
    logic [RAW_W-1:0]   altitude_raw;

    modport source (output valid, output altitude_raw, input ready);
    modport sink   (input valid, input altitude_raw, output ready);
endinterface

// ===== rtl/arrd_out_if.sv =====
// Output channel carrying one drum column record per transaction.
interface arrd_out_if;
    import arrd_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [COL_W-1:0]           column;
    logic [GLYPH_W-1:0]         glyph_next;
    logic [GLYPH_W-1:0]         glyph_current;
    logic [GLYPH_W-1:0]         glyph_prev;
    logic signed [OFFSET_W-1:0] drum_offset;
    logic                       last_column;

    modport source (output valid, output column, output glyph_next, output glyph_current,
                    output glyph_prev, output drum_offset, output last_column,
                    input ready);
    modport sink   (input valid, input column, input glyph_next, input glyph_current,
                    input glyph_prev, input drum_offset, input last_column,
                    output ready);
endinterface

// ===== rtl/altitude_rolling_digit_readout.sv =====
// Column 0 of an item passes the input, quotient, frame and output registers.
// Columns 1 to 3 follow one per cycle when the result channel does not stall.
// A word's frame is held until all four columns enter the single result channel.
// A new word is taken while earlier ones are still in the pipeline.
// Reset (rst_n low, asynchronous) empties all stages and zeroes the column counter.
module altitude_rolling_digit_readout (
    input  logic       clk,
    input  logic       rst_n,
    arrd_in_if.sink    altitude,
    arrd_out_if.source readout
);
    import arrd_pkg::*;

    logic        quot_valid;
    logic        quot_ready;
    arrd_quot_t  quot;
    arrd_frame_t frame;

    arrd_split u_split (
        .clk        (clk),
        .rst_n      (rst_n),
        .altitude   (altitude),
        .quot_valid (quot_valid),
        .quot       (quot),
        .quot_ready (quot_ready)
    );

    arrd_columns u_columns (
        .quot  (quot),
        .frame (frame)
    );

    arrd_serializer u_serializer (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (quot_valid),
        .frame       (frame),
        .frame_ready (quot_ready),
        .readout     (readout)
    );
endmodule

// ===== rtl/arrd_split.sv =====
// Input register and decimal quotient stage (reciprocal multiplies by 10, 100, 1000).
module arrd_split (
    input  logic                clk,
    input  logic                rst_n,
    arrd_in_if.sink             altitude,
    output logic                quot_valid,
    output arrd_pkg::arrd_quot_t quot,
    input  logic                quot_ready
);
    import arrd_pkg::*;

    logic               s1_valid_reg, s1_valid_next;
    logic [RAW_W-1:0]   raw_reg;
    logic               q_valid_reg, q_valid_next;
    arrd_quot_t         quot_reg, quot_next;
    logic               s1_ready, s2_ready;
    logic [COUNT_W-1:0] n;
    logic [25:0]        prod10;
    logic [25:0]        prod100;
    logic [26:0]        prod1000;

    assign s2_ready       = !q_valid_reg || quot_ready;
    assign s1_ready       = !s1_valid_reg || s2_ready;
    assign altitude.ready = s1_ready;

    assign s1_valid_next = s1_ready ? altitude.valid : s1_valid_reg;
    assign q_valid_next  = s2_ready ? s1_valid_reg : q_valid_reg;

    always_comb
    begin
        n         = raw_reg[RAW_W-1:FRAC_W];
        prod10    = 26'(n) * 26'(RECIP_10);
        prod100   = 26'(n) * 26'(RECIP_100);
        prod1000  = 27'(n) * 27'(RECIP_1000);
        quot_next.n    = n;
        quot_next.frac = raw_reg[FRAC_W-1:0] & FRAC_W'(FRAC_MASK);
        quot_next.q1   = prod10[25:16];
        quot_next.q2   = prod100[25:19];
        quot_next.q3   = prod1000[26:23];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            q_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            q_valid_reg  <= q_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && altitude.valid)
            raw_reg <= altitude.altitude_raw;
        if (s2_ready && s1_valid_reg)
            quot_reg <= quot_next;
    end

    assign quot_valid = q_valid_reg;
    assign quot       = quot_reg;
endmodule

// ===== rtl/arrd_columns.sv =====
// Digit extraction, blanking and carry-roll offsets for all four drum columns.
module arrd_columns (
    input  arrd_pkg::arrd_quot_t  quot,
    output arrd_pkg::arrd_frame_t frame
);
    import arrd_pkg::*;

    logic [COUNT_W-1:0]         t1;
    logic [9:0]                 t2;
    logic [6:0]                 t3;
    logic [GLYPH_W-1:0]         d1, d2, d3, d4;
    logic                       low_mode;
    logic [6:0]                 g;
    logic [6:0]                 g_diff;
    logic [7:0]                 k_high_raw;
    logic [6:0]                 k_high;
    logic [3:0]                 k_low;
    logic                       carry_low, carry_high;
    logic signed [OFFSET_W-1:0] idle_pos;
    logic signed [OFFSET_W-1:0] lo_p0, lo_p1, hi_p0, hi_p2;

    always_comb
    begin
        t1 = quot.n - COUNT_W'(quot.q1) * COUNT_W'(10);
        t2 = quot.q1 - 10'(quot.q2) * 10'd10;
        t3 = quot.q2 - 7'(quot.q3) * 7'd10;
        d1 = t1[GLYPH_W-1:0];
        d2 = t2[GLYPH_W-1:0];
        d3 = t3[GLYPH_W-1:0];
        d4 = quot.q3;

        low_mode = quot.n < COUNT_W'(LOW_LIMIT);
        idle_pos = roll_offset(9'd0);

        // low mode: units drum follows the fraction, tens rolls on a units 9
        carry_low = (quot.frac > 3'd2) && (d1 == 4'd9);
        k_low     = {quot.frac - 3'd2, 1'b0};
        if (k_low > 4'(K_LOW_MAX))
            k_low = 4'(K_LOW_MAX);
        lo_p0 = roll_offset(9'(quot.frac) * 9'(LOW_SCALE));
        lo_p1 = carry_low ? roll_offset(9'(k_low) * 9'(LOW_SCALE)) : idle_pos;

        // high mode: g is units digit plus fraction in eighths
        g          = {d1[3:0], 3'b000} + 7'(quot.frac);
        carry_high = (g > 7'(CARRY_G)) && (d2 == 4'd9);
        g_diff     = g - 7'(CARRY_G);
        k_high_raw = {g_diff, 1'b0};
        if (k_high_raw > 8'(K_HIGH_MAX))
            k_high_raw = 8'(K_HIGH_MAX);
        k_high = k_high_raw[6:0];
        hi_p0  = roll_offset(9'(g) * 9'(HIGH_SCALE));
        hi_p2  = carry_high ? roll_offset(9'(k_high) * 9'(HIGH_SCALE)) : idle_pos;

        if (low_mode)
        begin
            frame[0] = make_col(d1, 1'b0, 1'b0, lo_p0);
            frame[1] = make_col(d2, quot.n < COUNT_W'(10), 1'b0, lo_p1);
            frame[2] = make_col(d3, 1'b1, 1'b0,
                                (carry_low && d2 == 4'd9) ? lo_p1 : idle_pos);
            frame[3] = make_col(4'd0, 1'b0, 1'b1, idle_pos);
        end
        else
        begin
            // units drum is a fixed zero in all three glyphs
            frame[0].glyph_next    = 4'd0;
            frame[0].glyph_current = 4'd0;
            frame[0].glyph_prev    = 4'd0;
            frame[0].drum_offset   = hi_p0;
            frame[1] = make_col(d2, 1'b0, 1'b0, hi_p0);
            frame[2] = make_col(d3, 1'b0, 1'b0, hi_p2);
            frame[3] = make_col(d4, quot.n < COUNT_W'(THOUSAND), 1'b0,
                                (carry_high && d3 == 4'd9) ? hi_p2 : idle_pos);
        end
    end
endmodule

// ===== rtl/arrd_serializer.sv =====
// Frame register and output register that send the four column records in order.
module arrd_serializer (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  frame_valid,
    input  arrd_pkg::arrd_frame_t frame,
    output logic                  frame_ready,
    arrd_out_if.source            readout
);
    import arrd_pkg::*;

    logic             frame_valid_reg, frame_valid_next;
    arrd_frame_t      frame_reg;
    logic [COL_W-1:0] col_reg, col_next;
    logic             out_valid_reg, out_valid_next;
    arrd_col_t        out_rec_reg;
    logic [COL_W-1:0] out_col_reg;
    logic             out_load;
    logic             frame_done;
    logic             frame_load;

    assign out_load    = frame_valid_reg && (!out_valid_reg || readout.ready);
    assign frame_done  = out_load && (col_reg == LAST_COL);
    assign frame_ready = !frame_valid_reg || frame_done;
    assign frame_load  = frame_ready && frame_valid;

    always_comb
    begin
        frame_valid_next = frame_valid_reg;
        if (frame_load)
            frame_valid_next = 1'b1;
        else if (frame_done)
            frame_valid_next = 1'b0;

        col_next = out_load ? col_reg + 2'd1 : col_reg;

        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (readout.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_valid_reg <= 1'b0;
            col_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            frame_valid_reg <= frame_valid_next;
            col_reg         <= col_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_load)
            frame_reg <= frame;
        if (out_load)
        begin
            out_rec_reg <= frame_reg[col_reg];
            out_col_reg <= col_reg;
        end
    end

    assign readout.valid         = out_valid_reg;
    assign readout.column        = out_col_reg;
    assign readout.glyph_next    = out_rec_reg.glyph_next;
    assign readout.glyph_current = out_rec_reg.glyph_current;
    assign readout.glyph_prev    = out_rec_reg.glyph_prev;
    assign readout.drum_offset   = out_rec_reg.drum_offset;
    assign readout.last_column   = (out_col_reg == LAST_COL);

`ifndef SYNTHESIS
    // an empty frame always restarts at column 0
    a_col_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !frame_valid_reg |-> col_reg == '0)
        else $error("column counter not at zero with empty frame");

    // the rest of a frame stays held until its last column is sent
    a_frame_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_col_reg != LAST_COL) |-> frame_valid_reg)
        else $error("frame released before last column");

    // counter tracks the column just loaded into the output register
    a_col_seq: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (out_valid_reg && col_reg == out_col_reg + 2'd1))
        else $error("column sequence broken");
`endif
endmodule

// ===== tb/sv/tb_altitude_rolling_digit_readout.sv =====
// Self-checking testbench for the four-column rolling-drum altitude readout.
`timescale 1ns / 100ps

module tb_altitude_rolling_digit_readout;
    import arrd_pkg::*;

    localparam int CYCLE_LIMIT  = 60000;
    localparam int RANDOM_WORDS = 187;
    localparam int HOLD_CYCLES  = 90;
    localparam int HOLD_AFTER   = 120;   // results seen before the long hold-off
    localparam int IDLE_PCT     = 7;

    typedef struct {
        logic [COL_W-1:0]           column;
        logic [GLYPH_W-1:0]         glyph_next;
        logic [GLYPH_W-1:0]         glyph_current;
        logic [GLYPH_W-1:0]         glyph_prev;
        logic signed [OFFSET_W-1:0] drum_offset;
        logic                       last_column;
    } column_rec_t;

    logic clk;
    logic rst_n;

    arrd_in_if  altitude_ch ();
    arrd_out_if readout_ch ();

    altitude_rolling_digit_readout u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .altitude (altitude_ch),
        .readout  (readout_ch)
    );

    logic [RAW_W-1:0] altitude_q[$];
    column_rec_t      column_exp_q[$];
    int               mismatches;
    int               words_sent;
    int               results_seen;
    int               hold_left;
    logic             hold_done;
    int               cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_failure(input string msg);
        if (mismatches < 10)
            $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic logic signed [OFFSET_W-1:0] drum_pos(input int v, input int scale);
        int p;
        p = ((v * scale) / 4 - BASE_POS) * 2;
        return p[OFFSET_W-1:0];
    endfunction

    function automatic logic [GLYPH_W-1:0] glyph_code(input int d, input bit blank_zero,
                                                      input bit all_blank);
        if (all_blank || (blank_zero && d == 0))
            return BLANK_CODE;
        return d[GLYPH_W-1:0];
    endfunction

    function automatic column_rec_t drum_column(input int col, input int d,
                                                input bit blank_zero, input bit all_blank,
                                                input logic signed [OFFSET_W-1:0] pos);
        column_rec_t r;
        r.column        = col[COL_W-1:0];
        r.glyph_next    = glyph_code((d + 1) % 10, blank_zero, all_blank);
        r.glyph_current = glyph_code(d, blank_zero, all_blank);
        r.glyph_prev    = glyph_code((d + 9) % 10, blank_zero, all_blank);
        r.drum_offset   = pos;
        r.last_column   = (col == NUM_COLS - 1);
        return r;
    endfunction

    // Expected four column records for one altitude word, column 0 first.
    function automatic void predict_columns(input logic [RAW_W-1:0] raw);
        int                         f;
        int                         n;
        int                         d1;
        int                         d2;
        int                         d3;
        int                         d4;
        int                         g;
        int                         k;
        logic signed [OFFSET_W-1:0] rest_pos;
        logic signed [OFFSET_W-1:0] p0;
        logic signed [OFFSET_W-1:0] p1;
        logic signed [OFFSET_W-1:0] p2;
        logic signed [OFFSET_W-1:0] p3;
        column_rec_t                r;
        f  = raw & FRAC_MASK;
        n  = raw >> FRAC_W;
        d1 = n % 10;
        d2 = (n / 10) % 10;
        d3 = (n / 100) % 10;
        d4 = n / THOUSAND;
        rest_pos = drum_pos(0, 0);
        if (n < LOW_LIMIT)
        begin
            p1 = rest_pos;
            p2 = rest_pos;
            p3 = rest_pos;
            if (f > 2 && d1 == 9)
            begin
                k  = (2 * (f - 2) > K_LOW_MAX) ? K_LOW_MAX : 2 * (f - 2);
                p1 = drum_pos(k, LOW_SCALE);
                if (d2 == 9)
                    p2 = p1;
            end
            p0 = drum_pos(f, LOW_SCALE);
            column_exp_q.push_back(drum_column(0, d1, 1'b0, 1'b0, p0));
            column_exp_q.push_back(drum_column(1, d2, n < 10, 1'b0, p1));
            column_exp_q.push_back(drum_column(2, d3, 1'b1, 1'b0, p2));
            column_exp_q.push_back(drum_column(3, 0, 1'b0, 1'b1, p3));
        end
        else
        begin
            g  = f + 8 * d1;
            p2 = rest_pos;
            p3 = rest_pos;
            if (g > CARRY_G && d2 == 9)
            begin
                k  = (2 * (g - CARRY_G) > K_HIGH_MAX) ? K_HIGH_MAX : 2 * (g - CARRY_G);
                p2 = drum_pos(k, HIGH_SCALE);
                if (d3 == 9)
                    p3 = p2;
            end
            p0 = drum_pos(g, HIGH_SCALE);
            p1 = p0;
            // units drum is fixed at zero in all three windows
            r = drum_column(0, 0, 1'b0, 1'b0, p0);
            r.glyph_next = '0;
            r.glyph_prev = '0;
            column_exp_q.push_back(r);
            column_exp_q.push_back(drum_column(1, d2, 1'b0, 1'b0, p1));
            column_exp_q.push_back(drum_column(2, d3, 1'b0, 1'b0, p2));
            column_exp_q.push_back(drum_column(3, d4, n < THOUSAND, 1'b0, p3));
        end
    endfunction

    function automatic logic [RAW_W-1:0] pack_word(input int n, input int f);
        return {n[COUNT_W-1:0], f[FRAC_W-1:0]};
    endfunction

    // Sender: offers queued words, predicts on each accepted transaction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            altitude_ch.valid        <= 1'b0;
            altitude_ch.altitude_raw <= '0;
            words_sent = 0;
        end
        else
        begin
            if (altitude_ch.valid && altitude_ch.ready)
            begin
                predict_columns(altitude_ch.altitude_raw);
                words_sent++;
            end
            if (!altitude_ch.valid || altitude_ch.ready)
            begin
                if (altitude_q.size() != 0 &&
                    ((words_sent >= 100 && words_sent < 170) ||
                     $urandom_range(99) >= IDLE_PCT))
                begin
                    altitude_ch.valid        <= 1'b1;
                    altitude_ch.altitude_raw <= altitude_q.pop_front();
                end
                else
                    altitude_ch.valid <= 1'b0;
            end
        end
    end

    // One long receiver hold-off so the pipeline backs up into the input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && results_seen >= HOLD_AFTER)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Receiver: checks each column transaction against the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        column_rec_t e;
        if (!rst_n)
        begin
            readout_ch.ready <= 1'b0;
            results_seen = 0;
        end
        else
        begin
            if (readout_ch.valid && readout_ch.ready)
            begin
                results_seen++;
                if (column_exp_q.size() == 0)
                    report_failure($sformatf("unexpected column %0d offset %0d",
                                             readout_ch.column, readout_ch.drum_offset));
                else
                begin
                    e = column_exp_q.pop_front();
                    if (readout_ch.column !== e.column ||
                        readout_ch.glyph_next !== e.glyph_next ||
                        readout_ch.glyph_current !== e.glyph_current ||
                        readout_ch.glyph_prev !== e.glyph_prev ||
                        readout_ch.drum_offset !== e.drum_offset ||
                        readout_ch.last_column !== e.last_column)
                        report_failure($sformatf(
                            "exp %0d %0d/%0d/%0d %0d %0b got %0d %0d/%0d/%0d %0d %0b",
                            e.column, e.glyph_next, e.glyph_current, e.glyph_prev,
                            e.drum_offset, e.last_column,
                            readout_ch.column, readout_ch.glyph_next,
                            readout_ch.glyph_current, readout_ch.glyph_prev,
                            readout_ch.drum_offset, readout_ch.last_column));
                end
            end
            readout_ch.ready <= (hold_left == 0) &&
                                ((results_seen >= 420 && results_seen < 680) ||
                                 $urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("altitude_rolling_digit_readout test failed");
            $finish;
        end
    end

    initial
    begin
        int n;
        int f;
        int sel;
        int fixed_n[7];
        cycles     = 0;
        mismatches = 0;
        rst_n      = 1'b0;
        fixed_n    = '{9, 10, 99, 100, 999, 1000, 8191};

        // directed: zero, blanking edges, carry thresholds and caps, mode edges
        altitude_q.push_back(16'h0000);
        altitude_q.push_back(16'hFFFF);
        altitude_q.push_back(pack_word(5, 4));
        altitude_q.push_back(pack_word(9, 2));      // low carry just off
        altitude_q.push_back(pack_word(9, 3));      // low carry just on
        altitude_q.push_back(pack_word(9, 6));      // low roll at cap
        altitude_q.push_back(pack_word(9, 7));      // low roll clamped
        altitude_q.push_back(pack_word(10, 0));
        altitude_q.push_back(pack_word(49, 5));
        altitude_q.push_back(pack_word(99, 7));     // units, tens both rolling
        altitude_q.push_back(pack_word(100, 0));
        altitude_q.push_back(pack_word(193, 0));    // g at threshold, no roll
        altitude_q.push_back(pack_word(193, 1));    // g just past threshold
        altitude_q.push_back(pack_word(198, 0));    // high roll at cap
        altitude_q.push_back(pack_word(199, 7));    // high roll clamped
        altitude_q.push_back(pack_word(109, 7));    // tens not 9: no roll
        altitude_q.push_back(pack_word(999, 7));    // hundreds rolls too
        altitude_q.push_back(pack_word(1000, 0));   // thousands no longer blank
        altitude_q.push_back(pack_word(5990, 5));
        altitude_q.push_back(pack_word(8191, 0));
        altitude_q.push_back(pack_word(4096, 3));
        altitude_q.push_back(16'hAAAA);
        altitude_q.push_back(16'h5555);

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            f   = $urandom_range(7);
            sel = $urandom_range(9);
            case (sel)
                0, 1, 2: n = $urandom_range(8191);
                3, 4:    n = $urandom_range(99);
                5:       n = 10 * $urandom_range(9) + 9;
                6, 7:
                begin
                    n = 100 * $urandom_range(81, 1) + 90 + $urandom_range(9);
                    if (n > 8191)
                        n -= 100;
                end
                8:       n = 1000 * $urandom_range(7) + 990 + $urandom_range(9);
                default: n = fixed_n[$urandom_range(6)];
            endcase
            altitude_q.push_back(pack_word(n, f));
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (altitude_q.size() != 0 || altitude_ch.valid)
            @(posedge clk);
        while (column_exp_q.size() != 0)
            @(posedge clk);
        repeat (24) @(posedge clk);

        if (column_exp_q.size() != 0)
            report_failure($sformatf("%0d column records never arrived",
                                     column_exp_q.size()));
        if (mismatches == 0)
            $display("altitude_rolling_digit_readout test passed");
        else
            $display("altitude_rolling_digit_readout test failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/arrd_pkg.sv
rtl/arrd_in_if.sv
rtl/arrd_out_if.sv
rtl/arrd_split.sv
rtl/arrd_columns.sv
rtl/arrd_serializer.sv
rtl/altitude_rolling_digit_readout.sv
tb/sv/tb_altitude_rolling_digit_readout.sv
